[design/stodc_pkg.sv]
// Package: types, codes and helpers shared by the time-of-day clock files.
package stodc_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int FIELD_W  = 2;
    localparam int REPORT_W = 2;
    localparam int POS_W    = 4;
    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int DIGIT_W  = 4;

    // digits kept between bytes: HH, MM and the tens of SS
    localparam int DIGIT_SLOTS = 5;
    localparam int SLOT_W      = $clog2(DIGIT_SLOTS);

    typedef enum logic [MODE_W-1:0] {
        EV_TICK   = 3'd0,
        EV_MODE   = 3'd1,
        EV_SELECT = 3'd2,
        EV_INC    = 3'd3,
        EV_DEC    = 3'd4,
        EV_SERIAL = 3'd5
    } stodc_event_t;

    localparam logic [FIELD_W-1:0] FIELD_SEC  = 2'd0;
    localparam logic [FIELD_W-1:0] FIELD_MIN  = 2'd1;
    localparam logic [FIELD_W-1:0] FIELD_HOUR = 2'd2;

    localparam logic [REPORT_W-1:0] RPT_NONE = 2'd0;
    localparam logic [REPORT_W-1:0] RPT_TIME = 2'd1;
    localparam logic [REPORT_W-1:0] RPT_TEMP = 2'd2;

    // positions in the pattern WHH:MM:SS
    localparam logic [POS_W-1:0] POS_START  = 4'd0;
    localparam logic [POS_W-1:0] POS_HOUR_T = 4'd1;
    localparam logic [POS_W-1:0] POS_HOUR_U = 4'd2;
    localparam logic [POS_W-1:0] POS_COLON1 = 4'd3;
    localparam logic [POS_W-1:0] POS_MIN_T  = 4'd4;
    localparam logic [POS_W-1:0] POS_MIN_U  = 4'd5;
    localparam logic [POS_W-1:0] POS_COLON2 = 4'd6;
    localparam logic [POS_W-1:0] POS_SEC_T  = 4'd7;
    localparam logic [POS_W-1:0] POS_SEC_U  = 4'd8;

    localparam logic [SLOT_W-1:0] SLOT_HOUR_T = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_HOUR_U = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_MIN_T  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_MIN_U  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_SEC_T  = 3'd4;

    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_2     = 8'h32;
    localparam logic [BYTE_W-1:0] CH_3     = 8'h33;
    localparam logic [BYTE_W-1:0] CH_5     = 8'h35;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_W_LC  = 8'h77;
    localparam logic [BYTE_W-1:0] CH_W_UC  = 8'h57;
    localparam logic [BYTE_W-1:0] CH_R_UC  = 8'h52;
    localparam logic [BYTE_W-1:0] CH_T_UC  = 8'h54;

    localparam logic [SECOND_W-1:0] SEC_MAX  = 6'd59;
    localparam logic [MINUTE_W-1:0] MIN_MAX  = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_MAX = 5'd23;

    typedef struct packed {
        logic [SECOND_W-1:0] second_count;
        logic [MINUTE_W-1:0] minute_count;
        logic [HOUR_W-1:0]   hour_count;
        logic                setup_toggle;
        logic                first_run;
        logic [FIELD_W-1:0]  selected_field;
        logic [POS_W-1:0]    pattern_position;
    } stodc_state_t;

    localparam stodc_state_t STATE_RESET = '{
        second_count:     '0,
        minute_count:     '0,
        hour_count:       '0,
        setup_toggle:     1'b1,
        first_run:        1'b1,
        selected_field:   FIELD_SEC,
        pattern_position: POS_START
    };

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [DIGIT_W-1:0] value;
    } stodc_digit_wr_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour_now;
        logic [MINUTE_W-1:0] minute_now;
        logic [SECOND_W-1:0] second_now;
        logic                setup_active;
        logic [FIELD_W-1:0]  field_selected;
        logic                time_loaded;
        logic [REPORT_W-1:0] report_request;
        logic [POS_W-1:0]    parse_position;
    } stodc_result_t;

    // tens * 10 + units on decimal digits
    function automatic logic [6:0] tens_units(input logic [DIGIT_W-1:0] tens,
                                              input logic [DIGIT_W-1:0] units);
        logic [6:0] t7;
        t7 = {3'b000, tens};
        return (t7 << 3) + (t7 << 1) + {3'b000, units};
    endfunction

    function automatic logic in_range(input logic [BYTE_W-1:0] c,
                                      input logic [BYTE_W-1:0] lo,
                                      input logic [BYTE_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

endpackage

[design/stodc_if.sv]
// Interfaces: event channel and result channel with valid/ready handshake.
interface stodc_in_if;
    import stodc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface stodc_out_if;
    import stodc_pkg::*;

    logic                valid;
    logic                ready;
    logic [HOUR_W-1:0]   hour_now;
    logic [MINUTE_W-1:0] minute_now;
    logic [SECOND_W-1:0] second_now;
    logic                setup_active;
    logic [FIELD_W-1:0]  field_selected;
    logic                time_loaded;
    logic [REPORT_W-1:0] report_request;
    logic [POS_W-1:0]    parse_position;

    modport source (output valid, output hour_now, output minute_now, output second_now,
                    output setup_active, output field_selected, output time_loaded,
                    output report_request, output parse_position, input ready);
    modport sink   (input valid, input hour_now, input minute_now, input second_now,
                    input setup_active, input field_selected, input time_loaded,
                    input report_request, input parse_position, output ready);
endinterface

[design/settable_time_of_day_clock.sv]
// Top level: event-driven 24-hour clock with button setup and serial time load.
//
//  channel | dir | transaction
//  --------+-----+----------------------------------------------------------
//  evt     | in  | one event: mode (tick/buttons/serial), rx_byte
//  res     | out | time, setup flag, field, load flag, report, parse position
//
// One event per cycle sustained while the result is not stalled; results reach the
// ports via the event register, then the result register, fed by the update logic.
// Reset: time 00:00:00, first run; setup stays off until the second mode press.
// A stalled result holds the event register; evt.ready drops only when both are full.
module settable_time_of_day_clock (
    input  logic        clk,
    input  logic        rst_n,
    stodc_in_if.sink    evt,
    stodc_out_if.source res
);
    import stodc_pkg::*;

    logic                                 ev_valid_reg;
    logic [MODE_W-1:0]                    ev_mode_reg;
    logic [BYTE_W-1:0]                    ev_byte_reg;
    stodc_state_t                         state_reg;
    stodc_state_t                         state_next;
    logic [DIGIT_SLOTS-1:0][DIGIT_W-1:0]  digit_reg;
    stodc_digit_wr_t                      digit_wr;
    stodc_result_t                        res_reg;
    stodc_result_t                        res_next;
    logic                                 res_valid_reg;
    logic                                 advance;

    assign advance   = ev_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !ev_valid_reg || advance;

    stodc_step u_step (
        .state      (state_reg),
        .digits     (digit_reg),
        .mode       (ev_mode_reg),
        .rx_byte    (ev_byte_reg),
        .state_next (state_next),
        .digit_wr   (digit_wr),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (evt.ready)
            begin
                ev_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            ev_mode_reg <= evt.mode;
            ev_byte_reg <= evt.rx_byte;
        end
        if (advance)
        begin
            res_reg <= res_next;
            if (digit_wr.en)
            begin
                digit_reg[digit_wr.slot] <= digit_wr.value;
            end
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.hour_now       = res_reg.hour_now;
    assign res.minute_now     = res_reg.minute_now;
    assign res.second_now     = res_reg.second_now;
    assign res.setup_active   = res_reg.setup_active;
    assign res.field_selected = res_reg.field_selected;
    assign res.time_loaded    = res_reg.time_loaded;
    assign res.report_request = res_reg.report_request;
    assign res.parse_position = res_reg.parse_position;

endmodule

[design/stodc_step.sv]
// Next-state and result logic for one clock event.
module stodc_step (
    input  stodc_pkg::stodc_state_t                                   state,
    input  logic [stodc_pkg::DIGIT_SLOTS-1:0][stodc_pkg::DIGIT_W-1:0] digits,
    input  logic [stodc_pkg::MODE_W-1:0]                              mode,
    input  logic [stodc_pkg::BYTE_W-1:0]                              rx_byte,
    output stodc_pkg::stodc_state_t                                   state_next,
    output stodc_pkg::stodc_digit_wr_t                                digit_wr,
    output stodc_pkg::stodc_result_t                                  result
);
    import stodc_pkg::*;

    logic               in_setup;
    logic               fits;
    logic               loaded;
    logic [REPORT_W-1:0] report;
    logic [DIGIT_W-1:0] digit_val;
    logic [SECOND_W-1:0] sec_inc;
    logic [MINUTE_W-1:0] min_inc;
    logic [HOUR_W-1:0]   hour_inc;
    logic [SECOND_W-1:0] sec_dec;
    logic [MINUTE_W-1:0] min_dec;
    logic [HOUR_W-1:0]   hour_dec;
    logic [6:0]          hour_load;
    logic [6:0]          min_load;
    logic [6:0]          sec_load;

    assign in_setup  = !state.first_run && state.setup_toggle;
    assign digit_val = DIGIT_W'(rx_byte - CH_0);

    assign sec_inc  = (state.second_count >= SEC_MAX) ? '0 : state.second_count + 6'd1;
    assign min_inc  = (state.minute_count >= MIN_MAX) ? '0 : state.minute_count + 6'd1;
    assign hour_inc = (state.hour_count >= HOUR_MAX) ? '0 : state.hour_count + 5'd1;
    assign sec_dec  = (state.second_count == '0) ? SEC_MAX : state.second_count - 6'd1;
    assign min_dec  = (state.minute_count == '0) ? MIN_MAX : state.minute_count - 6'd1;
    assign hour_dec = (state.hour_count == '0) ? HOUR_MAX : state.hour_count - 5'd1;

    assign hour_load = tens_units(digits[SLOT_HOUR_T], digits[SLOT_HOUR_U]);
    assign min_load  = tens_units(digits[SLOT_MIN_T], digits[SLOT_MIN_U]);
    assign sec_load  = tens_units(digits[SLOT_SEC_T], digit_val);

    always_comb
    begin
        fits = 1'b0;
        digit_wr.en    = 1'b0;
        digit_wr.slot  = SLOT_HOUR_T;
        digit_wr.value = digit_val;
        unique case (state.pattern_position)
            POS_START:
            begin
                fits = (rx_byte == CH_W_LC) || (rx_byte == CH_W_UC);
            end
            POS_HOUR_T:
            begin
                fits = in_range(rx_byte, CH_0, CH_2);
                digit_wr.en   = 1'b1;
                digit_wr.slot = SLOT_HOUR_T;
            end
            POS_HOUR_U:
            begin
                fits = (digits[SLOT_HOUR_T] == 4'd2) ? in_range(rx_byte, CH_0, CH_3)
                                                     : in_range(rx_byte, CH_0, CH_9);
                digit_wr.en   = 1'b1;
                digit_wr.slot = SLOT_HOUR_U;
            end
            POS_COLON1, POS_COLON2:
            begin
                fits = (rx_byte == CH_COLON);
            end
            POS_MIN_T:
            begin
                fits = in_range(rx_byte, CH_0, CH_5);
                digit_wr.en   = 1'b1;
                digit_wr.slot = SLOT_MIN_T;
            end
            POS_MIN_U:
            begin
                fits = in_range(rx_byte, CH_0, CH_9);
                digit_wr.en   = 1'b1;
                digit_wr.slot = SLOT_MIN_U;
            end
            POS_SEC_T:
            begin
                fits = in_range(rx_byte, CH_0, CH_5);
                digit_wr.en   = 1'b1;
                digit_wr.slot = SLOT_SEC_T;
            end
            POS_SEC_U:
            begin
                fits = in_range(rx_byte, CH_0, CH_9);
            end
            default:
            begin
                fits = 1'b0;
            end
        endcase
        digit_wr.en = digit_wr.en && fits && (mode == EV_SERIAL);
    end

    always_comb
    begin
        state_next = state;
        loaded     = 1'b0;
        report     = RPT_NONE;
        unique case (mode)
            EV_TICK:
            begin
                if (!in_setup)
                begin
                    state_next.second_count = sec_inc;
                    if (state.second_count >= SEC_MAX)
                    begin
                        state_next.minute_count = min_inc;
                        if (state.minute_count >= MIN_MAX)
                        begin
                            state_next.hour_count = hour_inc;
                        end
                    end
                end
            end
            EV_MODE:
            begin
                state_next.first_run    = 1'b0;
                state_next.setup_toggle = !state.setup_toggle;
            end
            EV_SELECT:
            begin
                if (in_setup)
                begin
                    state_next.selected_field = (state.selected_field < FIELD_HOUR)
                                              ? state.selected_field + 2'd1 : FIELD_SEC;
                end
            end
            EV_INC:
            begin
                if (in_setup)
                begin
                    case (state.selected_field)
                        FIELD_SEC:  state_next.second_count = sec_inc;
                        FIELD_MIN:  state_next.minute_count = min_inc;
                        FIELD_HOUR: state_next.hour_count   = hour_inc;
                        default:    ;
                    endcase
                end
            end
            EV_DEC:
            begin
                if (in_setup)
                begin
                    case (state.selected_field)
                        FIELD_SEC:  state_next.second_count = sec_dec;
                        FIELD_MIN:  state_next.minute_count = min_dec;
                        FIELD_HOUR: state_next.hour_count   = hour_dec;
                        default:    ;
                    endcase
                end
            end
            EV_SERIAL:
            begin
                if (fits)
                begin
                    if (state.pattern_position == POS_SEC_U)
                    begin
                        state_next.pattern_position = POS_START;
                        state_next.hour_count   = hour_load[HOUR_W-1:0];
                        state_next.minute_count = min_load[MINUTE_W-1:0];
                        state_next.second_count = sec_load[SECOND_W-1:0];
                        loaded = 1'b1;
                    end
                    else
                    begin
                        state_next.pattern_position = state.pattern_position + 4'd1;
                    end
                end
                else
                begin
                    state_next.pattern_position = POS_START;
                    if (rx_byte == CH_R_UC)
                    begin
                        report = RPT_TIME;
                    end
                    else if (rx_byte == CH_T_UC)
                    begin
                        report = RPT_TEMP;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result.hour_now       = state_next.hour_count;
        result.minute_now     = state_next.minute_count;
        result.second_now     = state_next.second_count;
        result.setup_active   = !state_next.first_run && state_next.setup_toggle;
        result.field_selected = state_next.selected_field;
        result.time_loaded    = loaded;
        result.report_request = report;
        result.parse_position = state_next.pattern_position;
    end

endmodule

[design/stodc_checker.sv]
// Port checker for the time-of-day clock, bound to the top level.
module stodc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input logic [stodc_pkg::HOUR_W-1:0]         hour_now,
    input logic [stodc_pkg::MINUTE_W-1:0]       minute_now,
    input logic [stodc_pkg::SECOND_W-1:0]       second_now,
    input logic                                 time_loaded,
    input logic [stodc_pkg::REPORT_W-1:0]       report_request,
    input logic [stodc_pkg::POS_W-1:0]          parse_position
);
    import stodc_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(hour_now)
            && $stable(minute_now) && $stable(second_now) && $stable(parse_position))
        else $error("result changed while stalled");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> hour_now <= HOUR_MAX && minute_now <= MIN_MAX && second_now <= SEC_MAX)
        else $error("time out of range");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> parse_position <= POS_SEC_U)
        else $error("parse position out of range");

    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && time_loaded |-> parse_position == POS_START && report_request == RPT_NONE)
        else $error("time load did not restart parser");

    a_report_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && report_request != RPT_NONE |-> parse_position == POS_START)
        else $error("report request without parser restart");

endmodule

bind settable_time_of_day_clock stodc_checker u_stodc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .hour_now       (res.hour_now),
    .minute_now     (res.minute_now),
    .second_now     (res.second_now),
    .time_loaded    (res.time_loaded),
    .report_request (res.report_request),
    .parse_position (res.parse_position)
);
